>>> hdl/ialu_pkg.sv
// Shared types and constants for the integer ALU with multiply and divide.
// Depends on nothing; used by every module under hdl.
`default_nettype none
package ialu_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned ModeW = 5;

    typedef enum logic [ModeW-1:0] {
        MODE_ADD  = 5'd0,  MODE_ADDU = 5'd1,  MODE_SUB  = 5'd2,  MODE_SUBU = 5'd3,
        MODE_MUL  = 5'd4,  MODE_MULU = 5'd5,  MODE_DIV  = 5'd6,  MODE_DIVU = 5'd7,
        MODE_XOR  = 5'd8,  MODE_REM  = 5'd9,  MODE_REMU = 5'd10, MODE_NEG  = 5'd11,
        MODE_NOT  = 5'd12, MODE_SEQ  = 5'd13, MODE_SGE  = 5'd14, MODE_SGT  = 5'd15,
        MODE_SLE  = 5'd16, MODE_SLT  = 5'd17, MODE_SNE  = 5'd18
    } mode_t;

    // Result class carried down the pipe.
    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2,
        KIND_REM    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic             is_signed;
        logic [WordW-1:0] simple;
    } ctrl_t;
endpackage
`default_nettype wire

>>> hdl/ialu_simple.sv
// Combinational logic, compare and add/subtract results and result classing.
// Depends on ialu_pkg.
`default_nettype none
module ialu_simple (
    input  wire logic [ialu_pkg::ModeW-1:0] mode,
    input  wire logic [ialu_pkg::WordW-1:0] operand_a,
    input  wire logic [ialu_pkg::WordW-1:0] operand_b,
    output ialu_pkg::ctrl_t                 ctrl
);
    logic eq, lt;
    assign eq = (operand_a == operand_b);
    assign lt = ($signed(operand_a) < $signed(operand_b));

    always_comb begin
        ctrl = '{kind: ialu_pkg::KIND_SIMPLE, is_signed: 1'b0, simple: '0};
        case (mode)
            ialu_pkg::MODE_ADD, ialu_pkg::MODE_ADDU: ctrl.simple = operand_a + operand_b;
            ialu_pkg::MODE_SUB, ialu_pkg::MODE_SUBU: ctrl.simple = operand_a - operand_b;
            ialu_pkg::MODE_XOR: ctrl.simple = operand_a ^ operand_b;
            ialu_pkg::MODE_NEG: ctrl.simple = '0 - operand_a;
            ialu_pkg::MODE_NOT: ctrl.simple = ~operand_a;
            ialu_pkg::MODE_SEQ: ctrl.simple = {31'd0, eq};
            ialu_pkg::MODE_SGE: ctrl.simple = {31'd0, !lt};
            ialu_pkg::MODE_SGT: ctrl.simple = {31'd0, !lt && !eq};
            ialu_pkg::MODE_SLE: ctrl.simple = {31'd0, lt || eq};
            ialu_pkg::MODE_SLT: ctrl.simple = {31'd0, lt};
            ialu_pkg::MODE_SNE: ctrl.simple = {31'd0, !eq};
            ialu_pkg::MODE_MUL: begin
                ctrl.kind = ialu_pkg::KIND_MUL; ctrl.is_signed = 1'b1;
            end
            ialu_pkg::MODE_MULU: ctrl.kind = ialu_pkg::KIND_MUL;
            ialu_pkg::MODE_DIV: begin
                ctrl.kind = ialu_pkg::KIND_DIV; ctrl.is_signed = 1'b1;
            end
            ialu_pkg::MODE_DIVU: ctrl.kind = ialu_pkg::KIND_DIV;
            ialu_pkg::MODE_REM: begin
                ctrl.kind = ialu_pkg::KIND_REM; ctrl.is_signed = 1'b1;
            end
            ialu_pkg::MODE_REMU: ctrl.kind = ialu_pkg::KIND_REM;
            default: ctrl.simple = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/ialu_mul.sv
// Multiplier stage: 33x33 signed product of sign- or zero-extended operands.
// Depends on ialu_pkg.
`default_nettype none
module ialu_mul (
    input  wire logic                       aclk,
    input  wire logic                       enable,
    input  wire logic                       is_signed,
    input  wire logic [ialu_pkg::WordW-1:0] a,
    input  wire logic [ialu_pkg::WordW-1:0] b,
    output logic [2*ialu_pkg::WordW-1:0]    product
);
    logic signed [ialu_pkg::WordW:0]     ax, bx;
    logic signed [2*ialu_pkg::WordW+1:0] full;
    logic [2*ialu_pkg::WordW-1:0]        product_reg;

    assign ax   = {is_signed & a[ialu_pkg::WordW-1], a};
    assign bx   = {is_signed & b[ialu_pkg::WordW-1], b};
    assign full = ax * bx;

    always_ff @(posedge aclk) begin
        if (enable) begin
            product_reg <= full[2*ialu_pkg::WordW-1:0];
        end
    end
    assign product = product_reg;
endmodule
`default_nettype wire

>>> hdl/ialu_div_step.sv
// One combinational group of restoring-division steps on magnitudes.
// Depends on ialu_pkg.
`default_nettype none
module ialu_div_step #(
    parameter int unsigned STEPS = 4
) (
    input  wire logic [ialu_pkg::WordW-1:0] divisor,
    input  wire logic [ialu_pkg::WordW-1:0] rem_in,
    input  wire logic [ialu_pkg::WordW-1:0] quo_in,
    output logic [ialu_pkg::WordW-1:0]      rem_out,
    output logic [ialu_pkg::WordW-1:0]      quo_out
);
    // quo holds the not-yet-consumed dividend bits, shifting out at the top
    // while quotient bits shift in at the bottom.
    always_comb begin
        logic [ialu_pkg::WordW:0]   trial;
        logic [ialu_pkg::WordW-1:0] r, q;
        logic                       top;
        r     = rem_in;
        q     = quo_in;
        top   = 1'b0;
        trial = '0;
        for (int i = 0; i < int'(STEPS); i++) begin
            // The next dividend bit joins the partial remainder before the trial.
            top   = q[ialu_pkg::WordW-1];
            trial = {r, top} - {1'b0, divisor};
            q = {q[ialu_pkg::WordW-2:0], !trial[ialu_pkg::WordW]};
            if (!trial[ialu_pkg::WordW]) r = trial[ialu_pkg::WordW-1:0];
            else r = {r[ialu_pkg::WordW-2:0], top};
        end
        rem_out = r;
        quo_out = q;
    end
endmodule
`default_nettype wire

>>> hdl/integer_alu_with_muldiv.sv
// Integer ALU execute stage with full-width multiply and divide.
// Pipeline: input register,
// 8 division stages of 4 restoring steps each, sign fix-up into the output register.
// Throughput: one request per cycle while the result side does not stall; every unit is fully pipelined.
// A stall on the result side freezes the whole pipe; the input ready follows it.
// Reset (aresetn low, synchronous) clears all valid bits; data needs no reset.
`default_nettype none
module integer_alu_with_muldiv #(
    parameter int unsigned DIV_STEPS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [4:0] mode, [36:5] operand_a, [68:37] operand_b, [71:69] zero fill
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] result_low, [63:32] result_high, [64] divide_by_zero, [71:65] zero
    output logic [71:0]      m_tdata
);
    localparam int unsigned W      = ialu_pkg::WordW;
    localparam int unsigned NSTAGE = W / DIV_STEPS;   // division stages
    localparam int unsigned DEPTH  = NSTAGE + 2;       // pipe slots

    // The pipe advances whenever the output register is empty or being drained.
    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    logic [ialu_pkg::ModeW-1:0] in_mode;
    logic [W-1:0] in_a, in_b;
    assign in_mode = s_tdata[4:0];
    assign in_a    = s_tdata[36:5];
    assign in_b    = s_tdata[68:37];

    ialu_pkg::ctrl_t in_ctrl;
    ialu_simple u_simple (.mode(in_mode), .operand_a(in_a), .operand_b(in_b), .ctrl(in_ctrl));

    // Stage 0: register the request and take operand magnitudes.
    logic [DEPTH-1:0]   valid_reg;
    ialu_pkg::ctrl_t    ctrl_reg [NSTAGE+1];
    logic [W-1:0]       a_reg [NSTAGE+1];
    logic [W-1:0]       b_reg [NSTAGE+1];
    logic [W-1:0]       dvs_reg [NSTAGE+1];
    logic [W-1:0]       rem_reg [NSTAGE+1];
    logic [W-1:0]       quo_reg [NSTAGE+1];

    logic a_neg, b_neg;
    assign a_neg = in_ctrl.is_signed & in_a[W-1];
    assign b_neg = in_ctrl.is_signed & in_b[W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctrl_reg[0] <= in_ctrl;
            a_reg[0]    <= in_a;
            b_reg[0]    <= in_b;
            dvs_reg[0]  <= b_neg ? W'(-in_b) : in_b;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= a_neg ? W'(-in_a) : in_a;
        end
    end

    // The multiplier works on the incoming request, so its registered product
    // lines up with the stage 0 registers.
    logic [2*W-1:0] product;
    ialu_mul u_mul (.aclk(aclk), .enable(advance), .is_signed(in_ctrl.is_signed),
                    .a(in_a), .b(in_b), .product(product));

    logic [2*W-1:0] prod_reg [1:NSTAGE];

    for (genvar s = 1; s <= NSTAGE; s++) begin : g_div
        logic [W-1:0] r_n, q_n;
        ialu_div_step #(.STEPS(DIV_STEPS)) u_step (
            .divisor(dvs_reg[s-1]), .rem_in(rem_reg[s-1]), .quo_in(quo_reg[s-1]),
            .rem_out(r_n), .quo_out(q_n));
        always_ff @(posedge aclk) begin
            if (advance) begin
                ctrl_reg[s] <= ctrl_reg[s-1];
                a_reg[s]    <= a_reg[s-1];
                b_reg[s]    <= b_reg[s-1];
                dvs_reg[s]  <= dvs_reg[s-1];
                rem_reg[s]  <= r_n;
                quo_reg[s]  <= q_n;
                if (s == 1) prod_reg[s] <= product;
                else prod_reg[s] <= prod_reg[(s > 1) ? s-1 : s];
            end
        end
    end

    // Final stage: sign correction, special cases and result selection.
    localparam int unsigned L = NSTAGE;
    ialu_pkg::ctrl_t fc;
    logic [W-1:0]    fa, fb, fq, fr;
    logic            dz, qneg;
    logic [W-1:0]    lo_next, hi_next;
    assign fc   = ctrl_reg[L];
    assign fa   = a_reg[L];
    assign fb   = b_reg[L];
    assign dz   = (fb == '0);
    assign qneg = fc.is_signed & (fa[W-1] ^ fb[W-1]);
    assign fq   = qneg ? W'(-quo_reg[L]) : quo_reg[L];
    assign fr   = (fc.is_signed & fa[W-1]) ? W'(-rem_reg[L]) : rem_reg[L];

    // INT_MIN / -1 falls out naturally: magnitude quotient 2^31 wraps back.
    always_comb begin
        case (fc.kind)
            ialu_pkg::KIND_MUL: begin
                lo_next = prod_reg[L][W-1:0]; hi_next = prod_reg[L][2*W-1:W];
            end
            ialu_pkg::KIND_DIV: begin
                lo_next = dz ? '1 : fq; hi_next = dz ? fa : fr;
            end
            ialu_pkg::KIND_REM: begin
                lo_next = dz ? fa : fr; hi_next = '0;
            end
            default: begin
                lo_next = fc.simple; hi_next = '0;
            end
        endcase
    end

    logic [71:0] out_reg;
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= {7'd0, dz && (fc.kind == ialu_pkg::KIND_DIV
                                  || fc.kind == ialu_pkg::KIND_REM), hi_next, lo_next};
        end
    end
    assign m_tdata  = out_reg;
    assign m_tvalid = valid_reg[L+1];
endmodule
`default_nettype wire
